// File: src/assert_macros.svh
// assertion macros used by the sequencer core module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PFMS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfms same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define PFMS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfms next-cycle check failed");

`endif

// File: src/pfms_pkg.sv
// types, codes and helpers of the paper feed motor sequencer
`timescale 1ns / 1ps
package pfms_pkg;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic OP_CMD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_BACK  = 3'd1,
    PH_BRAKE = 3'd2,
    PH_WLOW  = 3'd3,
    PH_WHIGH = 3'd4,
    PH_PAUSE = 3'd5,
    PH_ROLL  = 3'd6
  } phase_t;

  localparam logic [1:0] DRV_COAST = 2'd0;
  localparam logic [1:0] DRV_FWD   = 2'd1;
  localparam logic [1:0] DRV_BACK  = 2'd2;
  localparam logic [1:0] DRV_BRAKE = 2'd3;

  localparam logic [2:0] RPL_CAUGHT    = 3'd0;
  localparam logic [2:0] RPL_ROLLED    = 3'd1;
  localparam logic [2:0] RPL_CATCHFAIL = 3'd2;
  localparam logic [2:0] RPL_JAM       = 3'd3;
  localparam logic [2:0] RPL_PONG      = 3'd4;
  localparam logic [2:0] RPL_UNKNOWN   = 3'd5;

  localparam logic [7:0] CMD_COAST = 8'd0;
  localparam logic [7:0] CMD_CATCH = 8'd1;
  localparam logic [7:0] CMD_ROLL  = 8'd2;
  localparam logic [7:0] CMD_PING  = 8'd30;

  localparam logic [2:0] REG_BACKWARD = 3'd0;
  localparam logic [2:0] REG_BRAKE    = 3'd1;
  localparam logic [2:0] REG_CATCH_TO = 3'd2;
  localparam logic [2:0] REG_RELEASE  = 3'd3;
  localparam logic [2:0] REG_PAUSE    = 3'd4;
  localparam logic [2:0] REG_ROLLOUT  = 3'd5;
  localparam logic [2:0] REG_MAX_ATT  = 3'd6;

  typedef struct packed {
    logic [15:0] backward_ticks;
    logic [15:0] brake_ticks;
    logic [15:0] catch_timeout;
    logic [15:0] release_timeout;
    logic [15:0] retry_pause_ticks;
    logic [15:0] rollout_ticks;
    logic [3:0]  max_attempts;
  } cfg_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] command_byte;
    logic       catch_sensor;
  } item_t;

  typedef struct packed {
    logic [1:0] motor_drive;
    logic       reply_valid;
    logic [2:0] reply_code;
    logic       busy_res;
  } res_t;

  function automatic logic phase_busy(input phase_t ph);
    return ph inside {[PH_BACK:PH_ROLL]};
  endfunction

endpackage

// File: src/pfms_in_if.sv
// input word channel: command bytes and ticks
`timescale 1ns / 1ps
interface pfms_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] command_byte;
  logic       catch_sensor;

  modport source(output valid, opcode, command_byte, catch_sensor, input ready);
  modport sink(input valid, opcode, command_byte, catch_sensor, output ready);
endinterface

// File: src/pfms_out_if.sv
// result word channel: motor drive and host reply
`timescale 1ns / 1ps
interface pfms_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] motor_drive;
  logic       reply_valid;
  logic [2:0] reply_code;
  logic       busy_res;

  modport source(output valid, motor_drive, reply_valid, reply_code, busy_res, input ready);
  modport sink(input valid, motor_drive, reply_valid, reply_code, busy_res, output ready);
endinterface

// File: src/pfms_cfg_regs.sv
// apb-style configuration registers of the sequencer
`timescale 1ns / 1ps
module pfms_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pfms_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pfms_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [pfms_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output pfms_pkg::cfg_t                  cfg
);
  import pfms_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_BACKWARD: cfg_nxt.backward_ticks    = pwdata[15:0];
        REG_BRAKE:    cfg_nxt.brake_ticks       = pwdata[15:0];
        REG_CATCH_TO: cfg_nxt.catch_timeout     = pwdata[15:0];
        REG_RELEASE:  cfg_nxt.release_timeout   = pwdata[15:0];
        REG_PAUSE:    cfg_nxt.retry_pause_ticks = pwdata[15:0];
        REG_ROLLOUT:  cfg_nxt.rollout_ticks     = pwdata[15:0];
        REG_MAX_ATT:  cfg_nxt.max_attempts      = pwdata[3:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.backward_ticks    <= 16'd50;
      cfg_r.brake_ticks       <= 16'd50;
      cfg_r.catch_timeout     <= 16'd500;
      cfg_r.release_timeout   <= 16'd1000;
      cfg_r.retry_pause_ticks <= 16'd50;
      cfg_r.rollout_ticks     <= 16'd400;
      cfg_r.max_attempts      <= 4'd3;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BACKWARD: prdata = {16'd0, cfg_r.backward_ticks};
      REG_BRAKE:    prdata = {16'd0, cfg_r.brake_ticks};
      REG_CATCH_TO: prdata = {16'd0, cfg_r.catch_timeout};
      REG_RELEASE:  prdata = {16'd0, cfg_r.release_timeout};
      REG_PAUSE:    prdata = {16'd0, cfg_r.retry_pause_ticks};
      REG_ROLLOUT:  prdata = {16'd0, cfg_r.rollout_ticks};
      REG_MAX_ATT:  prdata = {28'd0, cfg_r.max_attempts};
      default:      prdata = '0;
    endcase
  end

endmodule

// File: src/pfms_seq_core.sv
// sequencer state registers and single-pass next-state logic
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pfms_seq_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  pfms_pkg::item_t item,
  input  pfms_pkg::cfg_t  cfg,
  output pfms_pkg::res_t  res
);
  import pfms_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [15:0] ticks_r, ticks_nxt;
  logic [3:0]  att_r, att_nxt;
  logic [1:0]  drive_r, drive_nxt;
  logic        rv;
  logic [2:0]  rc;
  logic [15:0] cnt_inc;
  logic [3:0]  att_inc;

  assign cnt_inc = ticks_r + 16'd1;
  assign att_inc = att_r + 4'd1;

  always_comb begin
    phase_nxt = phase_r;
    ticks_nxt = ticks_r;
    att_nxt   = att_r;
    drive_nxt = drive_r;
    rv        = 1'b0;
    rc        = RPL_CAUGHT;
    if (item.opcode == OP_TICK) begin
      case (phase_r)
        PH_BACK: begin
          if (cnt_inc >= cfg.backward_ticks) begin
            phase_nxt = PH_BRAKE;
            ticks_nxt = '0;
            drive_nxt = DRV_BRAKE;
          end else begin
            ticks_nxt = cnt_inc;
          end
        end
        PH_BRAKE: begin
          if (cnt_inc >= cfg.brake_ticks) begin
            phase_nxt = PH_WLOW;
            ticks_nxt = '0;
            drive_nxt = DRV_FWD;
          end else begin
            ticks_nxt = cnt_inc;
          end
        end
        PH_WLOW: begin
          if (!item.catch_sensor) begin
            phase_nxt = PH_WHIGH;
            ticks_nxt = '0;
            drive_nxt = DRV_FWD;
          end else if (cnt_inc >= cfg.catch_timeout) begin
            // missed catch
            att_nxt   = att_inc;
            ticks_nxt = '0;
            if (cfg.retry_pause_ticks != 16'd0) begin
              phase_nxt = PH_PAUSE;
              drive_nxt = DRV_COAST;
            end else if (att_inc >= cfg.max_attempts) begin
              phase_nxt = PH_IDLE;
              drive_nxt = DRV_COAST;
              rv        = 1'b1;
              rc        = RPL_CATCHFAIL;
            end else begin
              phase_nxt = PH_BACK;
              drive_nxt = DRV_BACK;
            end
          end else begin
            ticks_nxt = cnt_inc;
          end
        end
        PH_WHIGH: begin
          if (item.catch_sensor) begin
            phase_nxt = PH_IDLE;
            ticks_nxt = '0;
            drive_nxt = DRV_COAST;
            rv        = 1'b1;
            rc        = RPL_CAUGHT;
          end else if (cnt_inc >= cfg.release_timeout) begin
            phase_nxt = PH_IDLE;
            ticks_nxt = '0;
            drive_nxt = DRV_COAST;
            rv        = 1'b1;
            rc        = RPL_JAM;
          end else begin
            ticks_nxt = cnt_inc;
          end
        end
        PH_PAUSE: begin
          if (cnt_inc >= cfg.retry_pause_ticks) begin
            ticks_nxt = '0;
            if (att_r >= cfg.max_attempts) begin
              phase_nxt = PH_IDLE;
              drive_nxt = DRV_COAST;
              rv        = 1'b1;
              rc        = RPL_CATCHFAIL;
            end else begin
              phase_nxt = PH_BACK;
              drive_nxt = DRV_BACK;
            end
          end else begin
            ticks_nxt = cnt_inc;
          end
        end
        PH_ROLL: begin
          if (cnt_inc >= cfg.rollout_ticks) begin
            phase_nxt = PH_IDLE;
            ticks_nxt = '0;
            drive_nxt = DRV_COAST;
            rv        = 1'b1;
            rc        = RPL_ROLLED;
          end else begin
            ticks_nxt = cnt_inc;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end else if (!phase_busy(phase_r)) begin
      phase_nxt = PH_IDLE;
      case (item.command_byte)
        CMD_COAST: drive_nxt = DRV_COAST;
        CMD_CATCH: begin
          att_nxt   = '0;
          phase_nxt = PH_BACK;
          ticks_nxt = '0;
          drive_nxt = DRV_BACK;
        end
        CMD_ROLL: begin
          phase_nxt = PH_ROLL;
          ticks_nxt = '0;
          drive_nxt = DRV_FWD;
        end
        CMD_PING: begin
          rv = 1'b1;
          rc = RPL_PONG;
        end
        default: begin
          rv = 1'b1;
          rc = RPL_UNKNOWN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      ticks_r <= '0;
      att_r   <= '0;
      drive_r <= DRV_COAST;
    end else if (step) begin
      phase_r <= phase_nxt;
      ticks_r <= ticks_nxt;
      att_r   <= att_nxt;
      drive_r <= drive_nxt;
    end
  end

  assign res.motor_drive = drive_nxt;
  assign res.reply_valid = rv;
  assign res.reply_code  = rc;
  assign res.busy_res    = phase_busy(phase_nxt);

  `PFMS_ASSERT_IMP(a_back_drive, phase_r == PH_BACK, drive_r == DRV_BACK)
  `PFMS_ASSERT_IMP(a_pause_coast, phase_r == PH_PAUSE, drive_r == DRV_COAST)
  `PFMS_ASSERT_IMP(a_reply_ends_seq, rv, !res.busy_res)
  `PFMS_ASSERT_NXT(a_busy_cmd_hold, step && item.opcode == OP_CMD && phase_busy(phase_r), phase_r == $past(phase_r))

endmodule

// File: src/paper_feed_motor_sequencer.sv
// an accepted word sits in the input register, then its result word in the result register
// throughput: one word per cycle unless out_ch stalls; both registers advance together
// the result register frees the input side whenever the result word is taken or empty
// reset: synchronous active-low rst_n clears both stages, the phase (idle) and counters
// reset: configuration registers return to their default values
`timescale 1ns / 1ps
module paper_feed_motor_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,
  pfms_in_if.sink                         in_ch,
  pfms_out_if.source                      out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [pfms_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [pfms_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [pfms_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import pfms_pkg::*;

  cfg_t  cfg;
  item_t item_r;
  logic  in_valid_r;
  res_t  res;
  res_t  res_r;
  logic  out_valid_r;
  logic  advance;
  logic  step;
  logic  in_acc;

  assign advance      = !out_valid_r || out_ch.ready;
  assign step         = in_valid_r && advance;
  assign in_ch.ready  = !in_valid_r || advance;
  assign in_acc       = in_ch.valid && in_ch.ready;

  pfms_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (cfg_psel),
    .penable(cfg_penable),
    .pwrite (cfg_pwrite),
    .paddr  (cfg_paddr),
    .pwdata (cfg_pwdata),
    .prdata (cfg_prdata),
    .pready (cfg_pready),
    .cfg    (cfg)
  );

  pfms_seq_core u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .step (step),
    .item (item_r),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_acc) begin
      in_valid_r <= 1'b1;
    end else if (step) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.opcode       <= in_ch.opcode;
      item_r.command_byte <= in_ch.command_byte;
      item_r.catch_sensor <= in_ch.catch_sensor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.motor_drive = res_r.motor_drive;
  assign out_ch.reply_valid = res_r.reply_valid;
  assign out_ch.reply_code  = res_r.reply_code;
  assign out_ch.busy_res    = res_r.busy_res;

endmodule

// File: bench/pfms_feed_checker.sv
// channel monitor with a result predictor and word-by-word comparison for the sequencer
`timescale 1ns / 1ps
module pfms_feed_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  pfms_in_if                              in_ch,
  pfms_out_if                             out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [pfms_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [pfms_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  input  logic                            cfg_pready,
  output int                              mismatches,
  output int                              words_due,
  output int                              words_checked,
  output int                              replies_caught,
  output int                              replies_jam,
  output int                              replies_fail,
  output int                              replies_rolled
);
  import pfms_pkg::*;

  cfg_t        regs;
  phase_t      ph;
  logic [15:0] ticks;
  logic [3:0]  tries;
  logic [1:0]  drive;
  logic        rep_v;
  logic [2:0]  rep_c;
  res_t        expected_words[$];
  int          bad = 0;
  int          checked = 0;
  int          n_caught = 0;
  int          n_jam = 0;
  int          n_fail = 0;
  int          n_rolled = 0;

  function automatic void go(input phase_t p, input logic [1:0] d);
    ph = p;
    ticks = '0;
    drive = d;
  endfunction

  function automatic void answer(input logic [2:0] code);
    rep_v = 1'b1;
    rep_c = code;
  endfunction

  function automatic logic count_reached(input logic [15:0] limit);
    ticks = ticks + 16'd1;
    return ticks >= limit;
  endfunction

  function automatic void after_pause();
    if (tries >= regs.max_attempts) begin
      go(PH_IDLE, DRV_COAST);
      answer(RPL_CATCHFAIL);
    end else begin
      go(PH_BACK, DRV_BACK);
    end
  endfunction

  function automatic res_t predict_word(input item_t w);
    res_t r;
    rep_v = 1'b0;
    rep_c = '0;
    if (w.opcode == OP_TICK) begin
      case (ph)
        PH_BACK: if (count_reached(regs.backward_ticks)) go(PH_BRAKE, DRV_BRAKE);
        PH_BRAKE: if (count_reached(regs.brake_ticks)) go(PH_WLOW, DRV_FWD);
        PH_WLOW: begin
          if (!w.catch_sensor) begin
            go(PH_WHIGH, DRV_FWD);
          end else if (count_reached(regs.catch_timeout)) begin
            tries = tries + 4'd1;
            go(PH_PAUSE, DRV_COAST);
            if (regs.retry_pause_ticks == 16'd0) after_pause();
          end
        end
        PH_WHIGH: begin
          if (w.catch_sensor) begin
            go(PH_IDLE, DRV_COAST);
            answer(RPL_CAUGHT);
          end else if (count_reached(regs.release_timeout)) begin
            go(PH_IDLE, DRV_COAST);
            answer(RPL_JAM);
          end
        end
        PH_PAUSE: if (count_reached(regs.retry_pause_ticks)) after_pause();
        PH_ROLL: begin
          if (count_reached(regs.rollout_ticks)) begin
            go(PH_IDLE, DRV_COAST);
            answer(RPL_ROLLED);
          end
        end
        default: ph = PH_IDLE;
      endcase
    end else if (ph == PH_IDLE) begin
      case (w.command_byte)
        CMD_COAST: drive = DRV_COAST;
        CMD_CATCH: begin
          tries = '0;
          go(PH_BACK, DRV_BACK);
        end
        CMD_ROLL: go(PH_ROLL, DRV_FWD);
        CMD_PING: answer(RPL_PONG);
        default: answer(RPL_UNKNOWN);
      endcase
    end
    r.motor_drive = drive;
    r.reply_valid = rep_v;
    r.reply_code  = rep_v ? rep_c : 3'd0;
    r.busy_res    = (ph != PH_IDLE);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want_v,
                                      input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, actual %0d", name, want_v, got_v);
      bad++;
    end
  endfunction

  always @(posedge clk) begin
    res_t  want;
    res_t  got;
    item_t w;
    if (!rst_n) begin
      regs = '{backward_ticks: 16'd50, brake_ticks: 16'd50, catch_timeout: 16'd500,
               release_timeout: 16'd1000, retry_pause_ticks: 16'd50,
               rollout_ticks: 16'd400, max_attempts: 4'd3};
      ph = PH_IDLE;
      ticks = '0;
      tries = '0;
      drive = DRV_COAST;
      expected_words.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[CFG_ADDR_W-1:2])
          REG_BACKWARD: regs.backward_ticks = cfg_pwdata[15:0];
          REG_BRAKE: regs.brake_ticks = cfg_pwdata[15:0];
          REG_CATCH_TO: regs.catch_timeout = cfg_pwdata[15:0];
          REG_RELEASE: regs.release_timeout = cfg_pwdata[15:0];
          REG_PAUSE: regs.retry_pause_ticks = cfg_pwdata[15:0];
          REG_ROLLOUT: regs.rollout_ticks = cfg_pwdata[15:0];
          REG_MAX_ATT: regs.max_attempts = cfg_pwdata[3:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.motor_drive, out_ch.reply_valid, out_ch.reply_code, out_ch.busy_res};
        if (expected_words.size() == 0) begin
          $error("result word arrived with no expectation waiting");
          bad++;
        end else begin
          want = expected_words.pop_front();
          check_field("motor_drive", 8'(want.motor_drive), 8'(got.motor_drive));
          check_field("reply_valid", 8'(want.reply_valid), 8'(got.reply_valid));
          check_field("reply_code", 8'(want.reply_code), 8'(got.reply_code));
          check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
          checked++;
          if (want.reply_valid) begin
            case (want.reply_code)
              RPL_CAUGHT: n_caught++;
              RPL_JAM: n_jam++;
              RPL_CATCHFAIL: n_fail++;
              RPL_ROLLED: n_rolled++;
              default: ;
            endcase
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        w = '{in_ch.opcode, in_ch.command_byte, in_ch.catch_sensor};
        expected_words.push_back(predict_word(w));
      end
    end
    mismatches     <= bad;
    words_due      <= expected_words.size();
    words_checked  <= checked;
    replies_caught <= n_caught;
    replies_jam    <= n_jam;
    replies_fail   <= n_fail;
    replies_rolled <= n_rolled;
  end

endmodule

// File: bench/tb_paper_feed_motor_sequencer.sv
// stimulus, idling and verdict for the paper feed motor sequencer bench
`timescale 1ns / 1ps
module tb_paper_feed_motor_sequencer;
  import pfms_pkg::*;

  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int RANDOM_WORDS = 330;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  int                    mismatches;
  int                    words_due;
  int                    words_checked;
  int                    replies_caught;
  int                    replies_jam;
  int                    replies_fail;
  int                    replies_rolled;
  int                    cycles = 0;
  int                    sent = 0;
  bit                    calm;
  cfg_t                  setting;

  pfms_in_if  in_ch();
  pfms_out_if out_ch();

  paper_feed_motor_sequencer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  pfms_feed_checker feed_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_pready     (cfg_pready),
    .mismatches     (mismatches),
    .words_due      (words_due),
    .words_checked  (words_checked),
    .replies_caught (replies_caught),
    .replies_jam    (replies_jam),
    .replies_fail   (replies_fail),
    .replies_rolled (replies_rolled)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int stall_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int capped_span(input logic [15:0] x);
    if (x == 16'd0) return 1;
    if (x > 16'd40) return 40;
    return int'(x);
  endfunction

  initial begin
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < 20) hold = stall_len();
      end
    end
  end

  task automatic send_word(input logic op, input logic [7:0] cb, input logic sen);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.command_byte <= cb;
    in_ch.catch_sensor <= sen;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic tick(input logic sen);
    send_word(OP_TICK, 8'($urandom), sen);
  endtask

  task automatic command(input logic [7:0] cb);
    send_word(OP_CMD, cb, 1'($urandom));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    logic [31:0] word;
    word = $urandom;
    if (idx == REG_MAX_ATT) word[3:0] = val[3:0];
    else word[15:0] = val;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
  endtask

  task automatic load_setting(input cfg_t s);
    write_reg(REG_BACKWARD, s.backward_ticks);
    write_reg(REG_BRAKE, s.brake_ticks);
    write_reg(REG_CATCH_TO, s.catch_timeout);
    write_reg(REG_RELEASE, s.release_timeout);
    write_reg(REG_PAUSE, s.retry_pause_ticks);
    write_reg(REG_ROLLOUT, s.rollout_ticks);
    write_reg(REG_MAX_ATT, {12'd0, s.max_attempts});
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    setting = s;
  endtask

  // ticks with the sensor low at the given percentage, a stray command now and then
  task automatic stir_ticks(input int span, input int p_low);
    repeat (span) begin
      if ($urandom_range(0, 99) < 5) command(8'($urandom));
      else tick(1'($urandom_range(0, 99) >= p_low));
    end
  endtask

  function automatic cfg_t pick_setting(input int k);
    cfg_t s;
    s.backward_ticks    = 16'($urandom_range(0, 3));
    s.brake_ticks       = 16'($urandom_range(0, 2));
    s.catch_timeout     = 16'($urandom_range(0, 4));
    s.release_timeout   = 16'($urandom_range(0, 4));
    s.retry_pause_ticks = 16'($urandom_range(0, 2));
    s.rollout_ticks     = 16'($urandom_range(0, 5));
    s.max_attempts      = 4'($urandom_range(0, 3));
    case (k)
      0: s = '0;
      1: s.max_attempts = 4'hF;
      2: begin
        s.catch_timeout   = 16'hFFFF;
        s.release_timeout = 16'hFFFF;
      end
      default: ;
    endcase
    return s;
  endfunction

  task automatic random_sequence();
    int r;
    int p_low;
    int tries;
    int span;
    r = $urandom_range(0, 99);
    p_low = 25 * $urandom_range(0, 4);
    if (setting.catch_timeout > 16'd100) p_low = $urandom_range(30, 70);
    tries = (setting.max_attempts == 4'd0) ? 1 : int'(setting.max_attempts);
    if (r < 50) begin
      span = tries * (capped_span(setting.backward_ticks) + capped_span(setting.brake_ticks)
             + capped_span(setting.catch_timeout) + capped_span(setting.retry_pause_ticks))
             + capped_span(setting.release_timeout) + 2;
      command(CMD_CATCH);
      stir_ticks(span, p_low);
    end else if (r < 70) begin
      command(CMD_ROLL);
      stir_ticks(capped_span(setting.rollout_ticks) + $urandom_range(0, 2), p_low);
    end else if (r < 78) begin
      command(CMD_PING);
    end else if (r < 83) begin
      command(CMD_COAST);
    end else if (r < 92) begin
      command(8'($urandom));
    end else begin
      stir_ticks($urandom_range(1, 4), p_low);
    end
  endtask

  initial begin
    int k;
    int start;
    rst_n              <= 1'b0;
    calm               <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.opcode       <= OP_CMD;
    in_ch.command_byte <= CMD_COAST;
    in_ch.catch_sensor <= 1'b1;
    cfg_psel           <= 1'b0;
    cfg_penable        <= 1'b0;
    cfg_pwrite         <= 1'b0;
    cfg_paddr          <= '0;
    cfg_pwdata         <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // idle decoding under the reset settings
    command(CMD_PING);
    command(CMD_COAST);
    command(8'hFF);
    command(8'd31);
    tick(1'b0);
    tick(1'b1);
    drain();
    load_setting('{backward_ticks: 16'd2, brake_ticks: 16'd1, catch_timeout: 16'd3,
                   release_timeout: 16'd2, retry_pause_ticks: 16'd1, rollout_ticks: 16'd1,
                   max_attempts: 4'd2});
    // roll-out with a ping ignored while busy
    command(CMD_ROLL);
    command(CMD_PING);
    tick(1'b1);
    // clean catch, then a jam
    command(CMD_CATCH);
    repeat (4) tick(1'b1);
    tick(1'b0);
    tick(1'b1);
    command(CMD_CATCH);
    repeat (3) tick(1'b1);
    repeat (3) tick(1'b0);
    drain();

    // full-range limits, no idling, roll-out left running into the next setting
    calm <= 1'b1;
    load_setting('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF});
    command(CMD_ROLL);
    command(CMD_PING);
    repeat (30) tick(1'($urandom));
    drain();
    calm <= 1'b0;

    start = sent;
    k = 0;
    while (sent - start < RANDOM_WORDS) begin
      drain();
      load_setting(pick_setting(k));
      k++;
      for (int j = 0; j < 6 && sent - start < RANDOM_WORDS; j++) begin
        random_sequence();
        if ($urandom_range(0, 9) == 0) drain();
      end
    end
    drain();

    $display("covered %0d input words over %0d settings, %0d result words compared",
             sent, k + 2, words_checked);
    $display("replies seen: %0d caught, %0d jam, %0d catch fail, %0d rolled out",
             replies_caught, replies_jam, replies_fail, replies_rolled);
    if (mismatches == 0 && words_due == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: paper_feed_motor_sequencer.f
+incdir+src
src/pfms_pkg.sv
src/pfms_in_if.sv
src/pfms_out_if.sv
src/pfms_cfg_regs.sv
src/pfms_seq_core.sv
src/paper_feed_motor_sequencer.sv
bench/pfms_feed_checker.sv
bench/tb_paper_feed_motor_sequencer.sv
